### rtl/mcmf_pkg.sv
// ----------------------------------------------------------------------------
// Min-cost max-flow package
// Controller state encoding and fixed arithmetic limits for the solver.
// ----------------------------------------------------------------------------
package mcmf_pkg;

  // Controller states, one-hot.
  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_INIT    = 17'b00000000000000010,
    S_SW_RD   = 17'b00000000000000100,
    S_SW_E    = 17'b00000000000001000,
    S_SW_NA   = 17'b00000000000010000,
    S_SW_NB   = 17'b00000000000100000,
    S_CHK_RD  = 17'b00000000001000000,
    S_CHK     = 17'b00000000010000000,
    S_T1_NODE = 17'b00000000100000000,
    S_T1_PRED = 17'b00000001000000000,
    S_T1_EDGE = 17'b00000010000000000,
    S_T2_NODE = 17'b00000100000000000,
    S_T2_PRED = 17'b00001000000000000,
    S_T2_EDGE = 17'b00010000000000000,
    S_T2_MUL  = 17'b00100000000000000,
    S_T2_ADD  = 17'b01000000000000000,
    S_DONE    = 17'b10000000000000000
  } mcmf_state_t;

  // Saturation limits of the cost total.
  localparam logic signed [63:0] COST_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] COST_MIN = 64'sh8000_0000_0000_0000;

  // Node count used after reset.
  localparam logic [10:0] NODE_COUNT_RST = 11'd2;

endpackage

### rtl/min_cost_max_flow_solver.sv
// Throughput: one edge item per cycle while in_stall is low; the last edge of a graph starts the solve.
// Each path search clears the node rows in use, runs up to n sweeps over the
// residual slots (slot read, tail node read, head node update) and checks the sink.
// Each augmentation walks the path back for the bottleneck, then walks it again
// to update residuals and add cost; the done state registers the total out.
// Reset is synchronous: it clears controller, edge count and total, not the RAMs.
// ----------------------------------------------------------------------------
// Min-cost max-flow solver
// Stores edge pairs in a RAM and runs successive Bellman-Ford searches over
// a node RAM, pushing bottleneck flow and summing a saturating cost.
// ----------------------------------------------------------------------------
module min_cost_max_flow_solver
  import mcmf_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [10:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [10:0]        in_from_node,
  input  logic [10:0]        in_to_node,
  input  logic [31:0]        in_capacity,
  input  logic signed [31:0] in_unit_cost,
  input  logic               in_last_edge,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_total_cost,
  output logic               out_cost_overflow
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int NCW   = NW + 1;
  localparam int PW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SW    = PW + 1;
  localparam int SCW   = PW + 2;
  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int ER_W  = 2 * NW + 96;
  localparam int NR_W  = SW + 65;

  mcmf_state_t state_r;

  logic [10:0]        node_count_r;
  logic [NCW-1:0]     n_r;
  logic [SCW-1:0]     stored_r;
  logic [SCW-1:0]     k_r;
  logic [NCW-1:0]     i_r;
  logic [NCW-1:0]     r_r;
  logic [NCW-1:0]     steps_r;
  logic               chg_r;
  logic [NW-1:0]      b_r;
  logic [NW-1:0]      v_r;
  logic signed [32:0] cost_r;
  logic signed [63:0] nd_r;
  logic [31:0]        push_r;
  logic               push_vld_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] total_r;
  logic               sat_r;
  logic               out_valid_r;
  logic signed [63:0] out_total_r;
  logic               out_ovf_r;

  // RAM ports.
  logic            e_we;
  logic [PW-1:0]   e_waddr, e_raddr;
  logic [ER_W-1:0] e_wdata, e_rdata;
  logic            n_we;
  logic [NW-1:0]   n_waddr, n_raddr;
  logic [NR_W-1:0] n_wdata, n_rdata;

  mcmf_ram #(.WIDTH(ER_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  mcmf_ram #(.WIDTH(NR_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  // Edge row fields; the row holds the forward slot and its reverse slot.
  logic [31:0]        e_cost, e_resr, e_resf;
  logic [NW-1:0]      e_head, e_tail;
  logic signed [32:0] cost_ext, slot_cost;
  logic [NW-1:0]      slot_tail, slot_head;
  logic [31:0]        slot_res;

  assign e_cost    = e_rdata[31:0];
  assign e_resr    = e_rdata[63:32];
  assign e_resf    = e_rdata[95:64];
  assign e_head    = e_rdata[96 +: NW];
  assign e_tail    = e_rdata[96+NW +: NW];
  assign cost_ext  = {e_cost[31], e_cost};
  assign slot_cost = k_r[0] ? -cost_ext : cost_ext;
  assign slot_tail = k_r[0] ? e_head : e_tail;
  assign slot_head = k_r[0] ? e_tail : e_head;
  assign slot_res  = k_r[0] ? e_resr : e_resf;

  // Node row fields.
  logic [SW-1:0]      n_pred;
  logic signed [63:0] n_dist;
  logic               n_reach;

  assign n_pred  = n_rdata[SW-1:0];
  assign n_dist  = n_rdata[SW +: 64];
  assign n_reach = n_rdata[SW+64];

  // Edge acceptance checks and clamped node count.
  logic           edge_ok;
  logic [NCW-1:0] n_eff;

  assign edge_ok = (in_from_node != 11'd0) && (int'(in_from_node) <= MAX_NODES) &&
                   (in_to_node != 11'd0) && (int'(in_to_node) <= MAX_NODES) &&
                   (int'(stored_r) + 2 <= SLOTS);

  always_comb begin
    if (node_count_r < 11'd2) begin
      n_eff = NCW'(2);
    end else if (int'(node_count_r) > MAX_NODES) begin
      n_eff = NCW'(MAX_NODES);
    end else begin
      n_eff = NCW'(node_count_r);
    end
  end

  // Sweep relaxation helpers.
  logic           e_skip;
  logic [NCW-1:0] n_last;

  assign e_skip = ({1'b0, slot_tail} >= n_r) || ({1'b0, slot_head} >= n_r) ||
                  (slot_res == 32'd0);
  assign n_last = n_r - NCW'(1);

  // Bottleneck tracking and residual update.
  logic [31:0] push_new;
  assign push_new = (!push_vld_r || slot_res < push_r) ? slot_res : push_r;

  logic [31:0] resf_upd, resr_upd;
  assign resf_upd = k_r[0] ? e_resf + push_r : e_resf - push_r;
  assign resr_upd = k_r[0] ? e_resr - push_r : e_resr + push_r;

  // Cost product and saturating sum.
  logic signed [65:0] mul_a, mul_b, mul_p;
  logic signed [64:0] sum_w;
  assign mul_a = {34'd0, push_r};
  assign mul_b = {{33{cost_r[32]}}, cost_r};
  assign mul_p = mul_a * mul_b;
  assign sum_w = {total_r[63], total_r} + {prod_r[63], prod_r};

  // RAM address and write control.
  always_comb begin
    e_we    = 1'b0;
    e_waddr = stored_r[PW:1];
    e_wdata = {NW'(in_from_node - 11'd1), NW'(in_to_node - 11'd1),
               in_capacity, 32'd0, in_unit_cost};
    e_raddr = k_r[PW:1];
    n_we    = 1'b0;
    n_waddr = i_r[NW-1:0];
    n_wdata = {(i_r == '0), 64'd0, {SW{1'b0}}};
    n_raddr = v_r;
    case (state_r)
      S_IDLE: begin
        e_we = in_valid && edge_ok;
      end
      S_INIT: begin
        n_we = 1'b1;
      end
      S_SW_E: begin
        n_raddr = slot_tail;
      end
      S_SW_NA: begin
        n_raddr = b_r;
      end
      S_SW_NB: begin
        n_we    = !n_reach || (nd_r < n_dist);
        n_waddr = b_r;
        n_wdata = {1'b1, nd_r, k_r[SW-1:0]};
      end
      S_CHK_RD: begin
        n_raddr = n_last[NW-1:0];
      end
      S_T1_PRED, S_T2_PRED: begin
        e_raddr = n_pred[SW-1:1];
      end
      S_T2_EDGE: begin
        e_we    = 1'b1;
        e_waddr = k_r[PW:1];
        e_wdata = {e_tail, e_head, resf_upd, resr_upd, e_cost};
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // Controller and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_COUNT_RST;
      stored_r     <= '0;
      total_r      <= '0;
      sat_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      chg_r        <= 1'b0;
      push_vld_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
      // The result register empties when taken; the done state refills it itself.
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        // Load one edge item per cycle.
        S_IDLE: begin
          if (in_valid) begin
            if (edge_ok) begin
              stored_r <= stored_r + SCW'(2);
            end
            if (in_last_edge) begin
              n_r     <= n_eff;
              i_r     <= '0;
              state_r <= S_INIT;
            end
          end
        end
        // Clear the node rows in use; the source starts reached.
        S_INIT: begin
          i_r <= i_r + NCW'(1);
          if (i_r == n_last) begin
            k_r     <= '0;
            r_r     <= '0;
            chg_r   <= 1'b0;
            state_r <= S_SW_RD;
          end
        end
        // Next residual slot, or end of a sweep.
        S_SW_RD: begin
          if (k_r == stored_r) begin
            if (!chg_r) begin
              state_r <= S_CHK_RD;
            end else if (r_r + NCW'(1) == n_r) begin
              state_r <= S_DONE;
            end else begin
              r_r   <= r_r + NCW'(1);
              k_r   <= '0;
              chg_r <= 1'b0;
            end
          end else begin
            state_r <= S_SW_E;
          end
        end
        S_SW_E: begin
          cost_r <= slot_cost;
          b_r    <= slot_head;
          if (e_skip) begin
            k_r     <= k_r + SCW'(1);
            state_r <= S_SW_RD;
          end else begin
            state_r <= S_SW_NA;
          end
        end
        S_SW_NA: begin
          nd_r <= n_dist + 64'(cost_r);
          if (!n_reach) begin
            k_r     <= k_r + SCW'(1);
            state_r <= S_SW_RD;
          end else begin
            state_r <= S_SW_NB;
          end
        end
        S_SW_NB: begin
          if (!n_reach || (nd_r < n_dist)) begin
            chg_r <= 1'b1;
          end
          k_r     <= k_r + SCW'(1);
          state_r <= S_SW_RD;
        end
        S_CHK_RD: begin
          state_r <= S_CHK;
        end
        // Sink reached: walk the path back for the bottleneck; else finish.
        S_CHK: begin
          if (n_reach) begin
            v_r        <= n_last[NW-1:0];
            steps_r    <= '0;
            push_vld_r <= 1'b0;
            state_r    <= S_T1_NODE;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_T1_NODE: begin
          state_r <= S_T1_PRED;
        end
        S_T1_PRED: begin
          k_r     <= SCW'(n_pred);
          state_r <= S_T1_EDGE;
        end
        S_T1_EDGE: begin
          push_r     <= push_new;
          push_vld_r <= 1'b1;
          steps_r    <= steps_r + NCW'(1);
          if (slot_tail == '0) begin
            if (push_new != 32'd0) begin
              v_r     <= n_last[NW-1:0];
              state_r <= S_T2_NODE;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            v_r <= slot_tail;
            if (steps_r + NCW'(1) == n_r) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_T1_NODE;
            end
          end
        end
        // Second walk: push flow and add its cost.
        S_T2_NODE: begin
          state_r <= S_T2_PRED;
        end
        S_T2_PRED: begin
          k_r     <= SCW'(n_pred);
          state_r <= S_T2_EDGE;
        end
        S_T2_EDGE: begin
          cost_r  <= slot_cost;
          v_r     <= slot_tail;
          state_r <= S_T2_MUL;
        end
        S_T2_MUL: begin
          prod_r  <= mul_p[63:0];
          state_r <= S_T2_ADD;
        end
        S_T2_ADD: begin
          if (sum_w[64] != sum_w[63]) begin
            total_r <= sum_w[64] ? COST_MIN : COST_MAX;
            sat_r   <= 1'b1;
          end else begin
            total_r <= sum_w[63:0];
          end
          if (v_r == '0) begin
            i_r     <= '0;
            state_r <= S_INIT;
          end else begin
            state_r <= S_T2_NODE;
          end
        end
        // Hand the total to the output register and clear for the next graph.
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_total_r <= total_r;
            out_ovf_r   <= sat_r;
            stored_r    <= '0;
            total_r     <= '0;
            sat_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_total_cost    = out_total_r;
  assign out_cost_overflow = out_ovf_r;

endmodule

### rtl/mcmf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mcmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min-cost max-flow solver testbench
// Feeds graphs edge by edge under random bursts and output stalls, predicts
// the min-cost max-flow total of each graph with a successive shortest path
// solver of its own, and compares every emitted total and overflow flag.
// ----------------------------------------------------------------------------
module tb_top
  import mcmf_pkg::*;
();

  localparam int NODE_LIMIT = 1024;
  localparam int EDGE_LIMIT = 4096;
  localparam int SLOT_LIMIT = 2 * EDGE_LIMIT;
  localparam int RANDOM_ITEMS = 1250;
  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [10:0] src_node;
    logic [10:0] dst_node;
    logic [31:0] capacity;
    logic [31:0] unit_cost;
    logic        last_edge;
  } edge_item_t;

  typedef struct {
    longint total;
    bit     overflow;
  } flow_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [10:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [10:0]        in_from_node;
  logic [10:0]        in_to_node;
  logic [31:0]        in_capacity;
  logic signed [31:0] in_unit_cost;
  logic               in_last_edge;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] out_total_cost;
  logic               out_cost_overflow;

  edge_item_t   pending_edges[$];
  flow_result_t expected_totals[$];
  int           errors = 0;
  longint       cycle_count = 0;

  // Predictor state: residual edge store, per-node search data and the total.
  int unsigned res_tail[SLOT_LIMIT];
  int unsigned res_head[SLOT_LIMIT];
  longint      res_cap[SLOT_LIMIT];
  longint      res_cost[SLOT_LIMIT];
  longint      res_flow[SLOT_LIMIT];
  longint      node_dist[NODE_LIMIT];
  int          node_pred[NODE_LIMIT];
  bit          node_seen[NODE_LIMIT];
  int unsigned slots_used = 0;
  longint      cost_sum = 0;
  bit          cost_saturated = 1'b0;
  int unsigned node_setting;

  min_cost_max_flow_solver u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_from_node     (in_from_node),
    .in_to_node       (in_to_node),
    .in_capacity      (in_capacity),
    .in_unit_cost     (in_unit_cost),
    .in_last_edge     (in_last_edge),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total_cost   (out_total_cost),
    .out_cost_overflow(out_cost_overflow)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Saturating accumulation of the cost total.
  function automatic void add_cost(longint delta);
    longint cmax;
    longint cmin;
    cmax = COST_MAX;
    cmin = COST_MIN;
    if (delta > 0 && cost_sum > cmax - delta) begin
      cost_sum = cmax;
      cost_saturated = 1'b1;
    end else if (delta < 0 && cost_sum < cmin - delta) begin
      cost_sum = cmin;
      cost_saturated = 1'b1;
    end else begin
      cost_sum = cost_sum + delta;
    end
  endfunction

  // Bellman-Ford from the source; true if the sink is reached with no
  // negative cycle still relaxing.
  function automatic bit search_path(int unsigned n);
    bit          changed;
    int unsigned sweep;
    int unsigned a;
    int unsigned b;
    longint      nd;
    changed = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      node_seen[i] = 1'b0;
      node_dist[i] = 0;
      node_pred[i] = -1;
    end
    node_seen[0] = 1'b1;
    for (sweep = 0; sweep < n && changed; sweep++) begin
      changed = 1'b0;
      for (int unsigned k = 0; k < slots_used; k++) begin
        a = res_tail[k];
        b = res_head[k];
        if (a < n && b < n && node_seen[a] && res_cap[k] - res_flow[k] > 0) begin
          nd = node_dist[a] + res_cost[k];
          if (!node_seen[b] || nd < node_dist[b]) begin
            node_seen[b] = 1'b1;
            node_dist[b] = nd;
            node_pred[b] = k;
            changed = 1'b1;
          end
        end
      end
    end
    if (changed) return 1'b0;
    return node_seen[n-1];
  endfunction

  // Successive shortest paths over the stored graph.
  function automatic void solve_flow();
    int unsigned n;
    int unsigned v;
    int unsigned steps;
    int unsigned k;
    longint      push;
    longint      room;
    n = node_setting;
    if (n < 2) n = 2;
    if (n > NODE_LIMIT) n = NODE_LIMIT;
    while (search_path(n)) begin
      push = -1;
      v = n - 1;
      steps = 0;
      while (v != 0 && steps < n) begin
        k = node_pred[v];
        room = res_cap[k] - res_flow[k];
        if (push < 0 || room < push) push = room;
        v = res_tail[k];
        steps++;
      end
      if (v != 0 || push <= 0) return;
      v = n - 1;
      while (v != 0) begin
        k = node_pred[v];
        res_flow[k] = res_flow[k] + push;
        res_flow[k ^ 1] = res_flow[k ^ 1] - push;
        add_cost(push * res_cost[k]);
        v = res_tail[k];
      end
    end
  endfunction

  // Stores one accepted edge and, on the last one, predicts the total.
  function automatic void predict_edge(edge_item_t e);
    int unsigned  a;
    int unsigned  b;
    longint       c;
    flow_result_t r;
    a = 32'(e.src_node);
    b = 32'(e.dst_node);
    c = longint'($signed(e.unit_cost));
    if (a >= 1 && a <= NODE_LIMIT && b >= 1 && b <= NODE_LIMIT &&
        slots_used + 2 <= SLOT_LIMIT) begin
      res_tail[slots_used]   = a - 1;
      res_head[slots_used]   = b - 1;
      res_cap[slots_used]    = longint'(e.capacity);
      res_cost[slots_used]   = c;
      res_flow[slots_used]   = 0;
      res_tail[slots_used+1] = b - 1;
      res_head[slots_used+1] = a - 1;
      res_cap[slots_used+1]  = 0;
      res_cost[slots_used+1] = -c;
      res_flow[slots_used+1] = 0;
      slots_used = slots_used + 2;
    end
    if (e.last_edge) begin
      solve_flow();
      r.total = cost_sum;
      r.overflow = cost_saturated;
      expected_totals.insert(expected_totals.size(), r);
      slots_used = 0;
      cost_sum = 0;
      cost_saturated = 1'b0;
    end
  endfunction

  function automatic edge_item_t make_edge(int unsigned a, int unsigned b,
                                           logic [31:0] cap, logic [31:0] cost,
                                           bit last);
    edge_item_t e;
    e.src_node = 11'(a);
    e.dst_node = 11'(b);
    e.capacity = cap;
    e.unit_cost = cost;
    e.last_edge = last;
    return e;
  endfunction

  // Appends one edge item to the driver's queue.
  function automatic void queue_edge(edge_item_t e);
    pending_edges.insert(pending_edges.size(), e);
  endfunction

  // Driver: bursts of items with random gaps, payload held while stalled.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= $urandom_range(1, 20);
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_edge(make_edge(32'(in_from_node), 32'(in_to_node), in_capacity,
                               in_unit_cost, in_last_edge));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_edges.size() > 0) begin
          edge_item_t e;
          e = pending_edges.pop_front();
          in_from_node <= e.src_node;
          in_to_node <= e.dst_node;
          in_capacity <= e.capacity;
          in_unit_cost <= e.unit_cost;
          in_last_edge <= e.last_edge;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted total and drives a changing stall pattern.
  int stall_mode;
  int mode_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      mode_left <= 100;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_totals.size() == 0) begin
          $error("unexpected total: total_cost %0d", out_total_cost);
          errors++;
        end else begin
          flow_result_t r;
          r = expected_totals.pop_front();
          if (out_total_cost !== r.total) begin
            $error("total_cost: expected %0d, actual %0d", r.total, out_total_cost);
            errors++;
          end
          if (out_cost_overflow !== r.overflow) begin
            $error("cost_overflow: expected %0d, actual %0d", r.overflow,
                   out_cost_overflow);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        default: out_stall <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  // Run length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_edges.size() > 0 || expected_totals.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_nodes(logic [10:0] n);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    node_setting = 32'(n);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One random graph: mostly edges inside the graph with small values,
  // some with random endpoints and full-width fields.
  task automatic queue_graph(int unsigned n, int unsigned m);
    int unsigned lim;
    int unsigned a;
    int unsigned b;
    logic [31:0] cap;
    logic [31:0] cost;
    lim = (n < 2) ? 2 : (n > NODE_LIMIT ? NODE_LIMIT : n);
    for (int unsigned i = 0; i < m; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 2047);
        b = $urandom_range(0, 2047);
        cap = $urandom();
        cost = $urandom();
      end else begin
        case ($urandom_range(0, 3))
          0: a = 1;
          1: a = lim;
          default: a = $urandom_range(1, lim);
        endcase
        b = ($urandom_range(0, 2) == 0) ? lim : $urandom_range(1, lim);
        cap = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 20);
        cost = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 30) - 5;
      end
      queue_edge(make_edge(a, b, cap, cost, i == m - 1));
    end
  endtask

  // Stimulus: directed graphs, then random graphs.
  initial begin
    int unsigned queued;
    int unsigned n;
    int unsigned m;
    int unsigned pick;
    node_setting = 32'(NODE_COUNT_RST);
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Single edge on the reset node count.
    queue_edge(make_edge(1, 2, 5, 3, 1));

    // Two paths, dropped endpoints and an edge outside the graph.
    write_nodes(4);
    queue_edge(make_edge(1, 2, 4, 1, 0));
    queue_edge(make_edge(2, 4, 3, 2, 0));
    queue_edge(make_edge(1, 3, 5, 4, 0));
    queue_edge(make_edge(3, 4, 6, -1, 0));
    queue_edge(make_edge(0, 4, 9, 1, 0));
    queue_edge(make_edge(1, 1025, 9, 1, 0));
    queue_edge(make_edge(2047, 2047, 9, 1, 0));
    queue_edge(make_edge(1, 7, 9, 1, 0));
    queue_edge(make_edge(2, 3, 0, -9, 1));

    // Negative cycle reachable from the source.
    write_nodes(3);
    queue_edge(make_edge(1, 3, 2, 5, 0));
    queue_edge(make_edge(1, 2, 5, -4, 0));
    queue_edge(make_edge(2, 1, 5, -4, 1));

    // Positive and negative saturation of the total.
    write_nodes(2);
    repeat (3) queue_edge(make_edge(1, 2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0));
    queue_edge(make_edge(1, 2, 1, 1, 1));
    repeat (3) queue_edge(make_edge(1, 2, 32'hFFFF_FFFF, 32'h8000_0000, 0));
    queue_edge(make_edge(0, 0, 0, 0, 1));

    // Node count clamped low and high, and the largest node count.
    write_nodes(0);
    queue_edge(make_edge(1, 2, 7, -2, 1));
    write_nodes(11'h7FF);
    queue_edge(make_edge(1, 1024, 3, 9, 1));
    write_nodes(1024);
    queue_edge(make_edge(1, 512, 3, 2, 0));
    queue_edge(make_edge(512, 1024, 2, 2, 1));

    // Random graphs, mostly small.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) n = $urandom_range(2, 6);
        else if (pick < 90) n = $urandom_range(7, 16);
        else if (pick < 95) n = $urandom_range(0, 2047);
        else n = 1024;
        write_nodes(11'(n));
      end else begin
        wait_idle();
      end
      m = $urandom_range(1, 8);
      queue_graph(node_setting, m);
      queued = queued + m;
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
